// ===== rtl/core/pglc_pkg.sv =====
// Shared types, codes, constants and the servo clamp function of the PIN gate lock controller.
package pglc_pkg;

    localparam int KEY_W   = 5;
    localparam int COUNT_W = 16;
    localparam int PULSE_W = 11;
    localparam int ACC_W   = 12;
    localparam int DIST_W  = 12;
    localparam int NEAR_W  = 8;
    localparam int PIN_W   = 16;
    localparam int MODE_W  = 2;
    localparam int EVENT_W = 2;
    localparam int DIG_W   = 3;
    localparam int RUN_W   = 6;
    localparam int PROD_W  = 34;

    // Key codes.
    localparam logic [KEY_W-1:0] KEY_DIGIT0 = 5'd1;
    localparam logic [KEY_W-1:0] KEY_DIGIT9 = 5'd10;
    localparam logic [KEY_W-1:0] KEY_CLEAR  = 5'd11;
    localparam logic [KEY_W-1:0] KEY_ENTER  = 5'd12;
    localparam logic [KEY_W-1:0] KEY_MINUS  = 5'd13;

    // Gate modes.
    localparam logic [MODE_W-1:0] MODE_LOCKED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSING = 2'd2;

    // Event codes.
    localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_GRANTED = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DENIED  = 2'd2;
    localparam logic [EVENT_W-1:0] EV_CLOSED  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_PIN_CODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_PULSE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSED_PULSE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_LIMIT   = 2'd3;

    localparam logic [PIN_W-1:0]   PIN_RESET    = 16'd4660;
    localparam logic [PULSE_W-1:0] OPEN_RESET   = 11'd1000;
    localparam logic [PULSE_W-1:0] CLOSED_RESET = 11'd2000;
    localparam logic [NEAR_W-1:0]  NEAR_RESET   = 8'd17;
    localparam logic [ACC_W-1:0]   PULSE_RESET  = 12'd2000;

    localparam logic [ACC_W-1:0]   PULSE_STEP = 12'd20;
    localparam logic [RUN_W-1:0]   MAX_RUN    = 6'd50;
    localparam logic [COUNT_W-1:0] ECHO_SAT   = 16'd60001;
    localparam logic [DIST_W-1:0]  NO_ECHO    = 12'd999;

    // Divide by 27: ceil(2^22 / 27) is exact for every count below 2^16.
    localparam logic [17:0] DIV_MULT  = 18'd155345;
    localparam int          DIV_SHIFT = 22;

    typedef struct packed {
        logic capture;
        logic mul;
        logic exec_pass;
        logic run_init;
        logic run_step;
    } cmd_t;

    typedef struct packed {
        logic grant;
        logic out_free;
        logic run_last;
    } status_t;

    function automatic logic [PULSE_W-1:0] servo_clamp(
        input logic [ACC_W-1:0]   pulse,
        input logic [PULSE_W-1:0] lo,
        input logic [PULSE_W-1:0] hi
    );
        logic [ACC_W-1:0] p;
        p = pulse;
        if (p < {1'b0, lo})
        begin
            p = {1'b0, lo};
        end
        if (p > {1'b0, hi})
        begin
            p = {1'b0, hi};
        end
        return p[PULSE_W-1:0];
    endfunction

endpackage

// ===== rtl/core/pglc_ctrl.sv =====
// Sequencing state machine of the PIN gate lock controller.
module pglc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pglc_pkg::status_t status,
    output pglc_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // A matching PIN turns into a run of servo steps.
                if (status.grant)
                begin
                    cmd.run_init = 1'b1;
                    state_next   = ST_RUN;
                end
                else if (status.out_free)
                begin
                    cmd.exec_pass = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.run_step = 1'b1;
                    if (status.run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/pglc_datapath.sv =====
// Gate state, configuration registers, distance divider and output register.
module pglc_datapath #(
    parameter int PIN_LENGTH = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [pglc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pglc_pkg::PIN_W-1:0]           cfg_data,
    input  logic [pglc_pkg::KEY_W-1:0]           key_code,
    input  logic                                 echo_timeout,
    input  logic [pglc_pkg::COUNT_W-1:0]         echo_count,
    input  pglc_pkg::cmd_t                       cmd,
    output pglc_pkg::status_t                    status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [pglc_pkg::PULSE_W-1:0]         servo_pulse,
    output logic                                 led_on,
    output logic [pglc_pkg::MODE_W-1:0]          gate_mode,
    output logic [pglc_pkg::DIG_W-1:0]           digits_entered,
    output logic [pglc_pkg::EVENT_W-1:0]         event_code,
    output logic [pglc_pkg::DIST_W-1:0]          distance_cm,
    output logic                                 last_result
);

    localparam int CW = $clog2(PIN_LENGTH + 1);

    // Configuration.
    logic [pglc_pkg::PIN_W-1:0]   pin_code_reg;
    logic [pglc_pkg::PULSE_W-1:0] open_pulse_reg;
    logic [pglc_pkg::PULSE_W-1:0] closed_pulse_reg;
    logic [pglc_pkg::NEAR_W-1:0]  near_limit_reg;

    // Gate state.
    logic [pglc_pkg::MODE_W-1:0]  mode_reg;
    logic [pglc_pkg::MODE_W-1:0]  mode_next;
    logic [pglc_pkg::ACC_W-1:0]   pulse_reg;
    logic [pglc_pkg::ACC_W-1:0]   pulse_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic                         lamp_reg;
    logic                         lamp_next;
    logic [3:0]                   digit_reg [PIN_LENGTH];
    logic [pglc_pkg::RUN_W-1:0]   run_cnt_reg;

    // Captured beat and the divider product.
    logic [pglc_pkg::KEY_W-1:0]   key_reg;
    logic                         tmo_reg;
    logic [pglc_pkg::COUNT_W-1:0] cnt_reg;
    logic [pglc_pkg::PROD_W-1:0]  prod_reg;

    // Output register.
    logic                         out_valid_reg;
    logic [pglc_pkg::PULSE_W-1:0] servo_reg;
    logic                         led_reg;
    logic [pglc_pkg::MODE_W-1:0]  gmode_reg;
    logic [pglc_pkg::DIG_W-1:0]   digits_reg;
    logic [pglc_pkg::EVENT_W-1:0] event_reg;
    logic [pglc_pkg::DIST_W-1:0]  dist_reg;
    logic                         last_reg;

    logic [pglc_pkg::COUNT_W-1:0] cnt_sat;
    logic [pglc_pkg::DIST_W-1:0]  dist_meas;
    logic [pglc_pkg::DIST_W-1:0]  pass_dist;
    logic [pglc_pkg::EVENT_W-1:0] pass_event;
    logic                         wr_digit;
    logic [31:0]                  pin_ext;
    logic                         match;
    logic                         step_down;
    logic [pglc_pkg::ACC_W-1:0]   pulse_dn;
    logic [pglc_pkg::ACC_W-1:0]   run_pulse;
    logic [pglc_pkg::RUN_W-1:0]   run_cnt_inc;
    logic                         run_last;
    logic                         out_free;

    assign cnt_sat   = (cnt_reg > pglc_pkg::ECHO_SAT) ? pglc_pkg::ECHO_SAT : cnt_reg;
    assign dist_meas = tmo_reg ? pglc_pkg::NO_ECHO
                               : prod_reg[pglc_pkg::PROD_W-1:pglc_pkg::DIV_SHIFT];

    // PIN compare: slot i holds the digit found in nibble PIN_LENGTH-1-i.
    assign pin_ext = {16'd0, pin_code_reg};

    always_comb
    begin
        match = (count_reg == CW'(PIN_LENGTH));
        for (int i = 0; i < PIN_LENGTH; i++)
        begin
            if (digit_reg[i] != pin_ext[(PIN_LENGTH - 1 - i) * 4 +: 4])
            begin
                match = 1'b0;
            end
        end
    end

    assign status.grant = (mode_reg != pglc_pkg::MODE_OPEN)
                       && (mode_reg != pglc_pkg::MODE_CLOSING)
                       && (key_reg == pglc_pkg::KEY_ENTER) && match;

    // One ordinary pass.
    always_comb
    begin
        mode_next  = mode_reg;
        pulse_next = pulse_reg;
        count_next = count_reg;
        lamp_next  = lamp_reg;
        pass_event = pglc_pkg::EV_NONE;
        pass_dist  = '0;
        wr_digit   = 1'b0;
        unique case (mode_reg)
            pglc_pkg::MODE_OPEN:
            begin
                pass_dist = dist_meas;
                if ((dist_meas != '0) && (dist_meas < {4'd0, near_limit_reg}))
                begin
                    lamp_next = 1'b1;
                    mode_next = pglc_pkg::MODE_CLOSING;
                end
                if (key_reg == pglc_pkg::KEY_MINUS)
                begin
                    mode_next = pglc_pkg::MODE_CLOSING;
                end
            end
            pglc_pkg::MODE_CLOSING:
            begin
                if (pulse_reg < {1'b0, closed_pulse_reg})
                begin
                    pulse_next = pulse_reg + pglc_pkg::PULSE_STEP;
                end
                else
                begin
                    lamp_next  = 1'b0;
                    mode_next  = pglc_pkg::MODE_LOCKED;
                    count_next = '0;
                    pass_event = pglc_pkg::EV_CLOSED;
                end
            end
            default:
            begin
                mode_next = pglc_pkg::MODE_LOCKED;
                if ((key_reg >= pglc_pkg::KEY_DIGIT0) && (key_reg <= pglc_pkg::KEY_DIGIT9))
                begin
                    if (count_reg < CW'(PIN_LENGTH))
                    begin
                        wr_digit   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (key_reg == pglc_pkg::KEY_CLEAR)
                begin
                    count_next = '0;
                end
                else if (key_reg == pglc_pkg::KEY_ENTER)
                begin
                    pass_event = pglc_pkg::EV_DENIED;
                    count_next = '0;
                end
            end
        endcase
    end

    // One step of the opening run; the step that ends the run is its final beat.
    assign step_down   = pulse_reg > {1'b0, open_pulse_reg};
    assign pulse_dn    = (pulse_reg >= pglc_pkg::PULSE_STEP) ? pulse_reg - pglc_pkg::PULSE_STEP
                                                             : '0;
    assign run_pulse   = step_down ? pulse_dn : pulse_reg;
    assign run_cnt_inc = run_cnt_reg + 1'b1;
    assign run_last    = !(run_pulse > {1'b0, open_pulse_reg})
                      || (run_cnt_inc == pglc_pkg::MAX_RUN);

    assign out_free        = !out_valid_reg || out_ready;
    assign status.out_free = out_free;
    assign status.run_last = run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_code_reg     <= pglc_pkg::PIN_RESET;
            open_pulse_reg   <= pglc_pkg::OPEN_RESET;
            closed_pulse_reg <= pglc_pkg::CLOSED_RESET;
            near_limit_reg   <= pglc_pkg::NEAR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pglc_pkg::REG_PIN_CODE:     pin_code_reg     <= cfg_data;
                pglc_pkg::REG_OPEN_PULSE:   open_pulse_reg   <= cfg_data[pglc_pkg::PULSE_W-1:0];
                pglc_pkg::REG_CLOSED_PULSE: closed_pulse_reg <= cfg_data[pglc_pkg::PULSE_W-1:0];
                pglc_pkg::REG_NEAR_LIMIT:   near_limit_reg   <= cfg_data[pglc_pkg::NEAR_W-1:0];
                default:                    pin_code_reg     <= pin_code_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= pglc_pkg::MODE_LOCKED;
            pulse_reg     <= pglc_pkg::PULSE_RESET;
            count_reg     <= '0;
            lamp_reg      <= 1'b0;
            run_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.run_init)
            begin
                run_cnt_reg <= '0;
            end
            if (cmd.exec_pass)
            begin
                mode_reg      <= mode_next;
                pulse_reg     <= pulse_next;
                count_reg     <= count_next;
                lamp_reg      <= lamp_next;
                out_valid_reg <= 1'b1;
            end
            else if (cmd.run_step)
            begin
                pulse_reg     <= run_pulse;
                run_cnt_reg   <= run_cnt_inc;
                out_valid_reg <= 1'b1;
                if (run_last)
                begin
                    mode_reg <= pglc_pkg::MODE_OPEN;
                    lamp_reg <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= key_code;
            tmo_reg <= echo_timeout;
            cnt_reg <= echo_count;
        end
        if (cmd.mul)
        begin
            prod_reg <= pglc_pkg::PROD_W'(cnt_sat) * pglc_pkg::PROD_W'(pglc_pkg::DIV_MULT);
        end
        for (int i = 0; i < PIN_LENGTH; i++)
        begin
            if (cmd.exec_pass && wr_digit && (count_reg == CW'(i)))
            begin
                digit_reg[i] <= 4'(key_reg - 5'd1);
            end
        end
        if (cmd.exec_pass)
        begin
            servo_reg  <= pglc_pkg::servo_clamp(pulse_next, open_pulse_reg, closed_pulse_reg);
            led_reg    <= lamp_next;
            gmode_reg  <= mode_next;
            digits_reg <= pglc_pkg::DIG_W'(count_next);
            event_reg  <= pass_event;
            dist_reg   <= pass_dist;
            last_reg   <= 1'b1;
        end
        else if (cmd.run_step)
        begin
            servo_reg  <= pglc_pkg::servo_clamp(run_pulse, open_pulse_reg, closed_pulse_reg);
            led_reg    <= !run_last;
            gmode_reg  <= run_last ? pglc_pkg::MODE_OPEN : pglc_pkg::MODE_LOCKED;
            digits_reg <= pglc_pkg::DIG_W'(count_reg);
            event_reg  <= pglc_pkg::EV_GRANTED;
            dist_reg   <= '0;
            last_reg   <= run_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign servo_pulse    = servo_reg;
    assign led_on         = led_reg;
    assign gate_mode      = gmode_reg;
    assign digits_entered = digits_reg;
    assign event_code     = event_reg;
    assign distance_cm    = dist_reg;
    assign last_result    = last_reg;

endmodule

// ===== rtl/core/pin_gate_lock_controller_unit.sv =====
// Top level of the PIN gate lock controller: stream ports, controller and datapath.
//
//  Channel   Direction  Handshake             Beat contents
//  s_*       in         s_tvalid / s_tready   one loop pass: key, echo timeout, echo count
//  m_*       out        m_tvalid / m_tready   one result; m_tlast marks the pass's final beat
//  cfg_*     in         cfg_valid / cfg_ready register write: cfg_index, cfg_data
//
// A pass runs through capture, divide-by-27 multiply and update, plus any wait on m_tready.
// An accepted PIN turns the update into one beat per servo step, 1 to 50 beats, each gated by m_tready.
// The next beat is accepted once the controller is back in idle; a waiting result is held
// in the output register meanwhile. Reset is asynchronous, active low, and takes effect
// at once; no clearing pass follows it. Configuration writes are taken in every cycle.
module pin_gate_lock_controller_unit #(
    parameter int PIN_LENGTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // key_code[4:0], echo_timeout[5], echo_count[21:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // servo_pulse[10:0], led_on[11], gate_mode[13:12],
                                    // digits_entered[16:14], event_code[18:17],
                                    // distance_cm[30:19], zero[31]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    pglc_pkg::cmd_t    cmd;
    pglc_pkg::status_t status;

    logic [pglc_pkg::PULSE_W-1:0] servo_pulse;
    logic                         led_on;
    logic [pglc_pkg::MODE_W-1:0]  gate_mode;
    logic [pglc_pkg::DIG_W-1:0]   digits_entered;
    logic [pglc_pkg::EVENT_W-1:0] event_code;
    logic [pglc_pkg::DIST_W-1:0]  distance_cm;

    assign cfg_ready = 1'b1;

    pglc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pglc_datapath #(
        .PIN_LENGTH (PIN_LENGTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .key_code       (s_tdata[4:0]),
        .echo_timeout   (s_tdata[5]),
        .echo_count     (s_tdata[21:6]),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .servo_pulse    (servo_pulse),
        .led_on         (led_on),
        .gate_mode      (gate_mode),
        .digits_entered (digits_entered),
        .event_code     (event_code),
        .distance_cm    (distance_cm),
        .last_result    (m_tlast)
    );

    assign m_tdata = {1'b0, distance_cm, event_code, digits_entered, gate_mode, led_on,
                      servo_pulse};

    // The controller never loads the output register while it holds a beat that m_tready does not take.
    assert_step_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.run_step || cmd.exec_pass) |-> status.out_free)
        else $error("result loaded into a busy output register");

    // Only one pass is in flight.
    assert_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("beat accepted while a pass is in progress");

    // A granted entry goes through the run, never through an ordinary pass.
    assert_grant_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec_pass |-> !status.grant)
        else $error("ordinary pass taken on a matching PIN");

    // A run step shows up on the output with the matching final-beat mark.
    assert_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_step |=> (m_tvalid && (m_tlast == $past(status.run_last))))
        else $error("run step not presented with its final-beat mark");

endmodule
